[rtl/fxalu_pkg.sv]
// Shared types and codes for the sign-magnitude 64.64 fixed-point ALU.
// Used by the channel interfaces and every pipeline stage; no dependencies.
`default_nettype none

package fxalu_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned HALF_W = 64;
    localparam int unsigned ST_W   = 3;
    localparam int unsigned CMP_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_NEG    = 3'd2,
        OP_HALVE  = 3'd3,
        OP_DOUBLE = 3'd4,
        OP_CMP    = 3'd5
    } t_op;

    localparam logic [ST_W-1:0] ST_NONNEG  = 3'd0;
    localparam logic [ST_W-1:0] ST_NEG     = 3'd1;
    localparam logic [ST_W-1:0] ST_POS_OVF = 3'd2;
    localparam logic [ST_W-1:0] ST_NEG_OVF = 3'd3;
    localparam logic [ST_W-1:0] ST_POS_UNF = 3'd4;
    localparam logic [ST_W-1:0] ST_NEG_UNF = 3'd5;

    localparam logic signed [CMP_W-1:0] CMP_LT = 2'sb11;
    localparam logic signed [CMP_W-1:0] CMP_EQ = 2'sb00;
    localparam logic signed [CMP_W-1:0] CMP_GT = 2'sb01;

    typedef struct packed {
        t_op               op;
        logic              a_neg;
        logic [HALF_W-1:0] a_whole;
        logic [HALF_W-1:0] a_frac;
        logic              b_neg;
        logic [HALF_W-1:0] b_whole;
        logic [HALF_W-1:0] b_frac;
        logic              a_zero;
        logic              w_gt;
        logic              w_eq;
        logic              f_gt;
        logic              f_eq;
    } t_s1;

    typedef struct packed {
        logic [HALF_W-1:0]        hi_a;
        logic [HALF_W-1:0]        hi_b;
        logic [HALF_W-1:0]        lo;
        logic                     carry;
        logic                     sub;
        logic                     neg;
        logic                     unf;
        logic signed [CMP_W-1:0]  cmp;
    } t_s2;

endpackage

`default_nettype wire

[rtl/fxalu_if.sv]
// Valid/ready channel interfaces for operand and result words.
// Depends on fxalu_pkg for field widths.
`default_nettype none

interface fxalu_in_if;
    logic                             valid;
    logic                             ready;
    logic [fxalu_pkg::OP_W-1:0]       operation;
    logic                             left_neg;
    logic [fxalu_pkg::HALF_W-1:0]     left_whole;
    logic [fxalu_pkg::HALF_W-1:0]     left_frac;
    logic                             right_neg;
    logic [fxalu_pkg::HALF_W-1:0]     right_whole;
    logic [fxalu_pkg::HALF_W-1:0]     right_frac;

    modport source (output valid, operation, left_neg, left_whole, left_frac,
                    right_neg, right_whole, right_frac, input ready);
    modport sink   (input valid, operation, left_neg, left_whole, left_frac,
                    right_neg, right_whole, right_frac, output ready);
endinterface

interface fxalu_out_if;
    logic                                valid;
    logic                                ready;
    logic [fxalu_pkg::ST_W-1:0]          result_status;
    logic [fxalu_pkg::HALF_W-1:0]        result_whole;
    logic [fxalu_pkg::HALF_W-1:0]        result_frac;
    logic signed [fxalu_pkg::CMP_W-1:0]  compare_result;

    modport source (output valid, result_status, result_whole, result_frac,
                    compare_result, input ready);
    modport sink   (input valid, result_status, result_whole, result_frac,
                    compare_result, output ready);
endinterface

`default_nettype wire

[rtl/sign_magnitude_fixed_point_alu_unit.sv]
// Sign-magnitude 64.64 fixed-point ALU: add, subtract, negate, halve,
// double and signed compare. Each accepted operand word passes through three
// registered stages to its result word: prep/compare, fraction, whole-part.
// Throughput is one word per cycle unless stalled; a stall holds each stage.
// Synchronous active-low reset empties all three stages; data is not cleared.
`default_nettype none

module sign_magnitude_fixed_point_alu_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fxalu_in_if.sink    i_in,
    fxalu_out_if.source o_out
);
    import fxalu_pkg::*;

    logic s1_valid;
    logic s2_ready;
    t_s1  s1;
    logic s2_valid;
    logic s3_ready;
    t_s2  s2;

    fxalu_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_s1    (s1)
    );

    fxalu_lo u_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .i_ready (s3_ready),
        .o_s2    (s2)
    );

    fxalu_hi u_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_s2    (s2),
        .o_out   (o_out)
    );

    a_cmp_clears_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.compare_result != CMP_EQ) |->
        (o_out.result_status == ST_NONNEG && o_out.result_whole == '0 &&
         o_out.result_frac == '0))
        else $error("compare word carries a nonzero value");

    a_cmp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.compare_result != 2'sb10))
        else $error("compare result out of range");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!s1_valid && !s2_valid && !o_out.valid))
        else $error("pipeline not empty after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !s1_valid && !s2_valid && !o_out.valid)
        |=> ##2 o_out.valid)
        else $error("word did not reach the output in three cycles");

endmodule

`default_nettype wire

[rtl/fxalu_prep.sv]
// Stage one: operand selection for subtract and double, zero detect and
// half-word magnitude compares. Depends on fxalu_pkg and fxalu_in_if.
`default_nettype none

module fxalu_prep (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    fxalu_in_if.sink             i_in,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output fxalu_pkg::t_s1       o_s1
);
    import fxalu_pkg::*;

    logic r_valid;
    t_s1  r_s1;
    t_s1  n_s1;
    logic b_zero;

    always_comb begin
        b_zero          = (i_in.right_whole == '0) && (i_in.right_frac == '0);
        n_s1.op         = t_op'(i_in.operation);
        n_s1.a_neg      = i_in.left_neg;
        n_s1.a_whole    = i_in.left_whole;
        n_s1.a_frac     = i_in.left_frac;
        n_s1.a_zero     = (i_in.left_whole == '0) && (i_in.left_frac == '0);
        n_s1.b_neg      = i_in.right_neg;
        n_s1.b_whole    = i_in.right_whole;
        n_s1.b_frac     = i_in.right_frac;
        case (n_s1.op)
            OP_SUB: begin
                n_s1.b_neg = i_in.right_neg ^ !b_zero;
            end
            OP_DOUBLE: begin
                n_s1.b_neg   = i_in.left_neg;
                n_s1.b_whole = i_in.left_whole;
                n_s1.b_frac  = i_in.left_frac;
            end
            default: begin
                n_s1.b_neg = i_in.right_neg;
            end
        endcase
        n_s1.w_gt = n_s1.a_whole > n_s1.b_whole;
        n_s1.w_eq = n_s1.a_whole == n_s1.b_whole;
        n_s1.f_gt = n_s1.a_frac > n_s1.b_frac;
        n_s1.f_eq = n_s1.a_frac == n_s1.b_frac;
    end

    assign i_in.ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

`default_nettype wire

[rtl/fxalu_lo.sv]
// Stage two: ordering of magnitudes, fraction add or subtract, negate,
// halve and compare. Depends on fxalu_pkg.
`default_nettype none

module fxalu_lo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire fxalu_pkg::t_s1  i_s1,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output fxalu_pkg::t_s2       o_s2
);
    import fxalu_pkg::*;

    logic r_valid;
    t_s2  r_s2;
    t_s2  n_s2;
    logic gt;
    logic eq;
    logic diff;

    always_comb begin
        gt   = i_s1.w_gt || (i_s1.w_eq && i_s1.f_gt);
        eq   = i_s1.w_eq && i_s1.f_eq;
        diff = i_s1.a_neg ^ i_s1.b_neg;
        n_s2 = '0;
        case (i_s1.op)
            OP_ADD, OP_SUB, OP_DOUBLE: begin
                if (diff) begin
                    if (!eq) begin
                        n_s2.sub = 1'b1;
                        if (gt) begin
                            n_s2.neg   = i_s1.a_neg;
                            n_s2.hi_a  = i_s1.a_whole;
                            n_s2.hi_b  = i_s1.b_whole;
                            n_s2.lo    = i_s1.a_frac - i_s1.b_frac;
                            n_s2.carry = !i_s1.f_gt && !i_s1.f_eq;
                        end else begin
                            n_s2.neg   = i_s1.b_neg;
                            n_s2.hi_a  = i_s1.b_whole;
                            n_s2.hi_b  = i_s1.a_whole;
                            n_s2.lo    = i_s1.b_frac - i_s1.a_frac;
                            n_s2.carry = i_s1.f_gt;
                        end
                    end
                end else begin
                    {n_s2.carry, n_s2.lo} = {1'b0, i_s1.a_frac} + {1'b0, i_s1.b_frac};
                    n_s2.neg  = i_s1.a_neg;
                    n_s2.hi_a = i_s1.a_whole;
                    n_s2.hi_b = i_s1.b_whole;
                end
            end
            OP_NEG: begin
                n_s2.neg  = i_s1.a_zero ? i_s1.a_neg : !i_s1.a_neg;
                n_s2.hi_a = i_s1.a_whole;
                n_s2.lo   = i_s1.a_frac;
            end
            OP_HALVE: begin
                n_s2.neg  = i_s1.a_neg;
                n_s2.hi_a = i_s1.a_whole >> 1;
                n_s2.lo   = {i_s1.a_whole[0], i_s1.a_frac[HALF_W-1:1]};
                n_s2.unf  = i_s1.a_frac[0];
            end
            OP_CMP: begin
                if (diff) begin
                    n_s2.cmp = i_s1.a_neg ? CMP_LT : CMP_GT;
                end else if (eq) begin
                    n_s2.cmp = CMP_EQ;
                end else begin
                    n_s2.cmp = (gt ^ i_s1.a_neg) ? CMP_GT : CMP_LT;
                end
            end
            default: begin
                n_s2 = '0;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

[rtl/fxalu_hi.sv]
// Stage three: whole-part add or subtract with the fraction carry, status
// encoding and the output register. Depends on fxalu_pkg and fxalu_out_if.
`default_nettype none

module fxalu_hi (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire fxalu_pkg::t_s2  i_s2,
    fxalu_out_if.source          o_out
);
    import fxalu_pkg::*;

    logic                    r_valid;
    logic [ST_W-1:0]         r_status;
    logic [HALF_W-1:0]       r_whole;
    logic [HALF_W-1:0]       r_frac;
    logic signed [CMP_W-1:0] r_cmp;
    logic [ST_W-1:0]         n_status;
    logic [HALF_W-1:0]       n_whole;
    logic [HALF_W:0]         sum;
    logic                    ovf;

    always_comb begin
        if (i_s2.sub) begin
            sum = {1'b0, i_s2.hi_a} - {1'b0, i_s2.hi_b} - {{HALF_W{1'b0}}, i_s2.carry};
        end else begin
            sum = {1'b0, i_s2.hi_a} + {1'b0, i_s2.hi_b} + {{HALF_W{1'b0}}, i_s2.carry};
        end
        n_whole = sum[HALF_W-1:0];
        ovf     = !i_s2.sub && sum[HALF_W];
        if (ovf) begin
            n_status = i_s2.neg ? ST_NEG_OVF : ST_POS_OVF;
        end else if (i_s2.unf) begin
            n_status = i_s2.neg ? ST_NEG_UNF : ST_POS_UNF;
        end else begin
            n_status = i_s2.neg ? ST_NEG : ST_NONNEG;
        end
    end

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_status <= n_status;
            r_whole  <= n_whole;
            r_frac   <= i_s2.lo;
            r_cmp    <= i_s2.cmp;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.result_status  = r_status;
    assign o_out.result_whole   = r_whole;
    assign o_out.result_frac    = r_frac;
    assign o_out.compare_result = r_cmp;

endmodule

`default_nettype wire
